@@ rtl/core/ksl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ksl_pkg: shared definitions for the keyed slot table
// Table size, field widths, operation and status codes, and the structures
// that move between the scan cells and the controller.
// ----------------------------------------------------------------------------
package ksl_pkg;

   localparam int SLOTS    = 16;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_W  = $clog2(SLOTS + 1);
   localparam int KEY_W    = 64;
   localparam int HANDLE_W = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_DUP      = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_HOLD
   } ctl_state_type;

   // Search token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic                valid;
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic                hit;
      logic [SLOT_W-1:0]   hit_idx;
      logic [HANDLE_W-1:0] hit_handle;
      logic                free_hit;
      logic [SLOT_W-1:0]   free_idx;
   } scan_type;

   // Update broadcast to every cell once the token has left the row.
   typedef struct packed {
      logic                write;
      logic                clear;
      logic [SLOT_W-1:0]   idx;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } commit_type;

endpackage
`default_nettype wire

@@ rtl/core/keyed_slot_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_slot_table_core: content-addressed session table
// Insert, remove and find on a fixed table of keyed slots, one transaction
// at a time, through a row of search cells.
// ----------------------------------------------------------------------------
// Each request launches a search token into a row of SLOTS cells. The token
// moves one cell per cycle, picking up the first slot whose key matches and
// the lowest free slot; when it leaves the last cell the controller decides
// the outcome, updates the chosen slot and the occupancy count, and posts the
// response. A new request is taken as soon as the previous one is decided,
// even if its response has not yet been collected; if an earlier response is
// still waiting when a search is decided, the result is parked and the input
// stalls until the output register frees. Reset clears every slot's valid bit
// and the count at once.
// ----------------------------------------------------------------------------
module keyed_slot_table_core
   import ksl_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [KEY_W-1:0]    req_key,
   input  wire logic [HANDLE_W-1:0] req_handle,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_slot_index,
   output logic [HANDLE_W-1:0]      rsp_found_handle,
   output logic [COUNT_W-1:0]       rsp_occupied
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   scan_type   inject;
   scan_type   chain [SLOTS+1];
   scan_type   tail;
   commit_type commit;
   logic [SLOTS-1:0] tok_valids;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic [STATUS_W-1:0] res_status;
   logic [SLOT_W-1:0]   res_idx;
   logic [HANDLE_W-1:0] res_handle;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_idx_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [STATUS_W-1:0] pend_status_ff;
   logic [SLOT_W-1:0]   pend_idx_ff;
   logic [HANDLE_W-1:0] pend_handle_ff;
   logic [COUNT_W-1:0]  pend_count_ff;

   logic accept;
   logic out_free;
   logic load_tail;
   logic load_pend;
   logic park_tail;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Token injected into the first cell.
   always_comb begin
      inject        = '0;
      inject.valid  = accept;
      inject.op     = req_operation;
      inject.key    = req_key;
      inject.handle = req_handle;
   end

   assign chain[0] = inject;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ksl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (SLOT_W'(i)),
         .prev_scan (chain[i]),
         .commit    (commit),
         .next_scan (chain[i+1])
      );
      assign tok_valids[i] = chain[i+1].valid;
   end

   assign tail = chain[SLOTS];

   // Outcome of the finished search and the slot update it implies.
   always_comb begin
      res_status = ST_NOTFOUND;
      res_idx    = '0;
      res_handle = '0;
      count_in   = count_ff;
      commit     = '0;
      commit.key    = tail.key;
      commit.handle = tail.handle;
      if (tail.valid) begin
         case (tail.op)
            OP_INSERT: begin
               if (count_ff >= COUNT_W'(SLOTS)) begin
                  res_status = ST_FULL;
               end else if (tail.hit) begin
                  res_status = ST_DUP;
               end else if (!tail.free_hit) begin
                  res_status = ST_FULL;
               end else begin
                  res_status   = ST_OK;
                  res_idx      = tail.free_idx;
                  commit.write = 1'b1;
                  commit.idx   = tail.free_idx;
                  count_in     = count_ff + COUNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (tail.hit) begin
                  res_status   = ST_OK;
                  res_idx      = tail.hit_idx;
                  commit.clear = 1'b1;
                  commit.idx   = tail.hit_idx;
                  count_in     = count_ff - COUNT_W'(1);
               end
            end
            OP_FIND: begin
               if (tail.hit) begin
                  res_status = ST_OK;
                  res_idx    = tail.hit_idx;
                  res_handle = tail.hit_handle;
               end
            end
            default: begin
               res_status = ST_NOTFOUND;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               state_in = CS_SCAN;
            end
         end
         CS_SCAN: begin
            if (tail.valid) begin
               state_in = out_free ? CS_IDLE : CS_HOLD;
            end
         end
         CS_HOLD: begin
            if (!rsp_stall) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load_tail = 1'b0;
      park_tail = 1'b0;
      load_pend = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_stall = 1'b0;
         end
         CS_SCAN: begin
            load_tail = tail.valid && out_free;
            park_tail = tail.valid && !out_free;
         end
         CS_HOLD: begin
            load_pend = !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      if (load_tail || load_pend || park_tail) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_tail) begin
         rsp_status_ff <= res_status;
         rsp_idx_ff    <= res_idx;
         rsp_handle_ff <= res_handle;
         rsp_count_ff  <= count_in;
      end else if (load_pend) begin
         rsp_status_ff <= pend_status_ff;
         rsp_idx_ff    <= pend_idx_ff;
         rsp_handle_ff <= pend_handle_ff;
         rsp_count_ff  <= pend_count_ff;
      end
      if (park_tail) begin
         pend_status_ff <= res_status;
         pend_idx_ff    <= res_idx;
         pend_handle_ff <= res_handle;
         pend_count_ff  <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_idx_ff;
   assign rsp_found_handle = rsp_handle_ff;
   assign rsp_occupied     = rsp_count_ff;

   // At most one search token is ever travelling along the row.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valids))
      else $error("more than one search token in the cell row");

   // A search is only in flight while the controller is scanning.
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      (tok_valids != '0) |-> (state_ff == CS_SCAN))
      else $error("search token outside the scan state");

   // A parked result always has a response ahead of it in the output register.
   a_hold_has_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_HOLD) |-> rsp_valid_ff)
      else $error("parked result without a pending response");

   // The occupancy count never exceeds the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(SLOTS))
      else $error("occupancy count beyond table size");

endmodule
`default_nettype wire

@@ rtl/core/ksl_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ksl_cell: one slot of the keyed slot table
// Holds a key, a handle and a valid bit, checks the passing search token
// against them and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module ksl_cell
   import ksl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SLOT_W-1:0] cell_id,
   input  wire scan_type          prev_scan,
   input  wire commit_type        commit,
   output scan_type               next_scan
);

   logic [KEY_W-1:0]    key_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic                valid_ff;
   logic                valid_in;
   scan_type            tok_ff;
   scan_type            tok_in;

   // Only the first matching cell records a hit, and only the first free cell records the free slot.
   always_comb begin
      tok_in = prev_scan;
      if (prev_scan.valid) begin
         if (valid_ff && (key_ff == prev_scan.key) && !prev_scan.hit) begin
            tok_in.hit        = 1'b1;
            tok_in.hit_idx    = cell_id;
            tok_in.hit_handle = handle_ff;
         end
         if (!valid_ff && !prev_scan.free_hit) begin
            tok_in.free_hit = 1'b1;
            tok_in.free_idx = cell_id;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (commit.idx == cell_id) begin
         if (commit.write) begin
            valid_in = 1'b1;
         end else if (commit.clear) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit.write && (commit.idx == cell_id)) begin
         key_ff    <= commit.key;
         handle_ff <= commit.handle;
      end
   end

   assign next_scan = tok_ff;

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the keyed slot table core
// A directed table walks the empty, duplicate, full and freed-slot cases. A
// long random run follows, with keys drawn from a small pool so that hits,
// duplicates and a full table keep recurring. A shadow copy of the table
// predicts each response that the directed table leaves open. Both channels
// idle at random, and one long response hold makes the core back up.
// ----------------------------------------------------------------------------
module tb_top
   import ksl_pkg::*;
;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 95;
   localparam int POOL_SIZE     = 24;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 3 * (SLOTS + 1);
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] handle;
      logic [COUNT_W-1:0]  occupied;
   } outcome_type;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      bit                  typed;
      outcome_type         outcome;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation;
   logic [KEY_W-1:0]    req_key;
   logic [HANDLE_W-1:0] req_handle;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic [HANDLE_W-1:0] rsp_found_handle;
   logic [COUNT_W-1:0]  rsp_occupied;

   // Shadow copy of the session table.
   logic [KEY_W-1:0]    shadow_key [SLOTS];
   logic [HANDLE_W-1:0] shadow_hnd [SLOTS];
   bit                  shadow_used [SLOTS];
   int                  shadow_count;

   outcome_type         outcome_q [$];
   stim_row_type        directed_rows [$];
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];

   int  mismatches = 0;
   int  cycle_count = 0;
   bit  send_idle;
   bit  rsp_idle;
   bit  hold_long = 1'b0;

   keyed_slot_table_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_handle       (req_handle),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_found_handle (rsp_found_handle),
      .rsp_occupied     (rsp_occupied)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Applies one operation to the shadow table and returns its response.
   function automatic outcome_type session_lookup(input logic [OP_W-1:0]     op,
                                                  input logic [KEY_W-1:0]    key,
                                                  input logic [HANDLE_W-1:0] hnd);
      outcome_type res;
      int          hit;
      int          vacant;
      res.status   = ST_NOTFOUND;
      res.slot     = '0;
      res.handle   = '0;
      hit          = -1;
      vacant       = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_used[i] && shadow_key[i] == key && hit < 0) hit = i;
         if (!shadow_used[i] && vacant < 0) vacant = i;
      end
      case (op)
         OP_INSERT: begin
            // A full table is reported ahead of a duplicate key.
            if (shadow_count >= SLOTS) begin
               res.status = ST_FULL;
            end else if (hit >= 0) begin
               res.status = ST_DUP;
            end else begin
               shadow_key[vacant]  = key;
               shadow_hnd[vacant]  = hnd;
               shadow_used[vacant] = 1'b1;
               shadow_count++;
               res.status = ST_OK;
               res.slot   = vacant[SLOT_W-1:0];
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               shadow_used[hit] = 1'b0;
               shadow_count--;
               res.status = ST_OK;
               res.slot   = hit[SLOT_W-1:0];
            end
         end
         OP_FIND: begin
            if (hit >= 0) begin
               res.status = ST_OK;
               res.slot   = hit[SLOT_W-1:0];
               res.handle = shadow_hnd[hit];
            end
         end
         default: ;
      endcase
      res.occupied = shadow_count[COUNT_W-1:0];
      return res;
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic [HANDLE_W-1:0] hnd, input bit typed,
                          input status_type status, input int slot,
                          input logic [HANDLE_W-1:0] found, input int occupied);
      stim_row_type row;
      row.op               = op;
      row.key              = key;
      row.handle           = hnd;
      row.typed            = typed;
      row.outcome.status   = status;
      row.outcome.slot     = slot[SLOT_W-1:0];
      row.outcome.handle   = found;
      row.outcome.occupied = occupied[COUNT_W-1:0];
      directed_rows.push_back(row);
   endtask

   // Offers one transaction, starting at a falling edge and returning at one.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [HANDLE_W-1:0] hnd, input bit typed,
                               input outcome_type typed_outcome);
      int          gap;
      outcome_type predicted;
      gap = send_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_handle    <= hnd;
      do @(posedge clock); while (req_stall);
      predicted = session_lookup(op, key, hnd);
      outcome_q.push_back(typed ? typed_outcome : predicted);
      @(negedge clock);
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch: %s", what);
   endtask

   // Response side: random stall before each transaction, plus one long hold.
   initial begin
      int gap;
      bit long_done;
      long_done = 1'b0;
      rsp_stall = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if (hold_long && !long_done) begin
            long_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            gap = rsp_idle ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            note_mismatch($sformatf("unexpected response status %0d slot %0d",
                                    rsp_status, rsp_slot_index));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_status !== want.status || rsp_slot_index !== want.slot ||
                rsp_found_handle !== want.handle || rsp_occupied !== want.occupied)
               note_mismatch($sformatf(
                  "exp st %0d slot %0d hnd %h occ %0d, got st %0d slot %0d hnd %h occ %0d",
                  want.status, want.slot, want.handle, want.occupied, rsp_status,
                  rsp_slot_index, rsp_found_handle, rsp_occupied));
         end
      end
   end

   initial begin
      outcome_type         blank;
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      int                  ins_pct;
      int                  pick;
      int                  fill;
      bit                  present;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = '0;
      req_key       = '0;
      req_handle    = '0;
      send_idle     = 1'b1;
      rsp_idle      = 1'b1;
      blank         = '0;
      shadow_count  = 0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_key[i]  = '0;
         shadow_hnd[i]  = '0;
         shadow_used[i] = 1'b0;
      end

      add_row(OP_FIND,   64'h0, 32'h0, 1, ST_NOTFOUND, 0, 32'h0, 0);
      add_row(OP_UNUSED, '1, '1, 1, ST_NOTFOUND, 0, 32'h0, 0);
      add_row(OP_INSERT, 64'h0, 32'h0, 1, ST_OK, 0, 32'h0, 1);
      add_row(OP_INSERT, '1, '1, 1, ST_OK, 1, 32'h0, 2);
      add_row(OP_INSERT, 64'h0, 32'h1234, 1, ST_DUP, 0, 32'h0, 2);
      add_row(OP_FIND,   '1, 32'h0, 1, ST_OK, 1, 32'hFFFF_FFFF, 2);
      add_row(OP_REMOVE, 64'h0, 32'h0, 1, ST_OK, 0, 32'h0, 1);
      // The freed lowest slot is taken again.
      add_row(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1, ST_OK, 0, 32'h0, 2);
      for (int i = 2; i < SLOTS; i++)
         add_row(OP_INSERT, 64'h100 + i, $urandom, 0, ST_OK, 0, 32'h0, 0);
      add_row(OP_INSERT, '1, 32'h0, 1, ST_FULL, 0, 32'h0, SLOTS);
      add_row(OP_REMOVE, 64'h107, 32'h0, 1, ST_OK, 7, 32'h0, SLOTS - 1);
      add_row(OP_FIND,   64'h107, 32'h0, 1, ST_NOTFOUND, 0, 32'h0, SLOTS - 1);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].handle,
                      directed_rows[i].typed, directed_rows[i].outcome);

      // Seed the key pool with what the table holds now, then fresh keys.
      fill = 0;
      for (int i = 0; i < SLOTS; i++)
         if (shadow_used[i] && fill < POOL_SIZE) begin
            key_pool[fill] = shadow_key[i];
            fill++;
         end
      for (int i = fill; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 2))
            0:       ins_pct = 80;
            1:       ins_pct = 45;
            default: ins_pct = 20;
         endcase
         send_idle = ($urandom_range(0, 3) != 0);
         rsp_idle  = ($urandom_range(0, 3) != 0);
         if (phase == 1) hold_long = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Now and then retire a pool key that is not in the table.
            if ($urandom_range(0, 99) < 3) begin
               pick    = $urandom_range(0, POOL_SIZE - 1);
               present = 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (shadow_used[i] && shadow_key[i] == key_pool[pick]) present = 1'b1;
               if (!present) key_pool[pick] = {$urandom, $urandom};
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) op = OP_UNUSED;
            else if (pick < 3 + ins_pct) op = OP_INSERT;
            else if ($urandom_range(0, 1) == 0) op = OP_REMOVE;
            else op = OP_FIND;
            if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
            else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(op, key, $urandom, 0, blank);
         end
      end
      req_valid <= 1'b0;

      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outcome_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire
